// ===== rtl/core/pfa_pkg.sv =====
// Shared types and constants for the paged frame allocator.
// No dependencies; every other file in rtl/core except pfa_ram imports this package.
`default_nettype none

package pfa_pkg;

  localparam int unsigned FRAMES_DEF = 256;  // default frame count
  localparam int unsigned ID_W       = 16;   // owner id width
  localparam int unsigned BYTES_W    = 16;   // size field width
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_CNT_W  = 9;    // reported count width
  localparam int unsigned QUO_W      = BYTES_W + 1;  // ceil numerator width

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } pfa_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_PAGE = 2'd1,
    ST_NO_ROOM  = 2'd2
  } pfa_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_TAIL,
    S_RESULT
  } pfa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic        clr_wr;     // clearing pass write at scan index
    logic        take;       // latch accepted request
    logic        div_start;  // start frame count division
    logic        left_load;  // load frames-to-allocate counter
    logic        scan_rd;    // read table entry at scan index
    logic        res_load;   // load result register
    pfa_status_e res_code;
  } pfa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;   // scan index at last frame
    logic is_free;    // latched request is a free
    logic page_zero;  // latched page size is zero
    logic div_done;
    logic need_ok;    // frame count nonzero and fits
    logic res_room;   // result register can take a result
  } pfa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
`default_nettype none

module pfa_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frame count.
// Depends on pfa_pkg.
`default_nettype none

module pfa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pfa_pkg::QUO_W-1:0]   num_i,
  input  logic [pfa_pkg::BYTES_W-1:0] den_i,
  output logic                      done_o,
  output logic [pfa_pkg::QUO_W-1:0]   quo_o
);
  import pfa_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [QUO_W-1:0]   a_q, a_d;    // numerator shifting out, quotient in
  logic [BYTES_W-1:0] r_q, r_d;
  logic [BYTES_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BYTES_W:0]   r_sh;
  logic [BYTES_W:0]   r_sub;
  logic               ge;

  always_comb begin
    r_sh   = {r_q, a_q[QUO_W-1]};
    ge     = r_sh >= {1'b0, den_q};
    r_sub  = r_sh - {1'b0, den_q};
    a_d    = a_q;
    r_d    = r_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = num_i;
      r_d    = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d   = {a_q[QUO_W-2:0], ge};
      r_d   = ge ? r_sub[BYTES_W-1:0] : r_sh[BYTES_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = a_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_dp.sv =====
// Datapath: request latch, frame table RAM, scan pipeline, counters, result.
// Depends on pfa_pkg, pfa_ram and pfa_div.
`default_nettype none

module pfa_dp #(
  parameter int unsigned FRAMES = pfa_pkg::FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfa_pkg::pfa_cmd_t             cmd_i,
  output pfa_pkg::pfa_sts_t             sts_o,
  input  logic                          func_i,
  input  logic [pfa_pkg::ID_W-1:0]      owner_id_i,
  input  logic [pfa_pkg::BYTES_W-1:0]   mem_bytes_i,
  input  logic [pfa_pkg::BYTES_W-1:0]   page_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pfa_pkg::STATUS_W-1:0]  status_o,
  output logic [pfa_pkg::OUT_CNT_W-1:0] frames_changed_o,
  output logic [pfa_pkg::OUT_CNT_W-1:0] free_frames_o
);
  import pfa_pkg::*;

  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned WW = ID_W + 1;  // {free, owner}

  // request
  pfa_func_e          func_q;
  logic [ID_W-1:0]    owner_q;
  logic [BYTES_W-1:0] mem_q;
  logic [BYTES_W-1:0] page_q;

  // scan
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] wr_idx_q;
  logic          rd_pend_q;
  logic          idx_last;

  // counts
  logic [CW-1:0] free_cnt_q, free_cnt_d;
  logic [CW-1:0] chg_q, chg_d;
  logic [CW-1:0] left_q, left_d;

  // result
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q;
  logic [OUT_CNT_W-1:0] changed_q;
  logic [OUT_CNT_W-1:0] free_out_q;
  logic [31:0]          chg_w;
  logic [31:0]          free_w;

  // table and divider
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;
  logic          rd_free;
  logic [ID_W-1:0] rd_owner;
  logic          hit;
  logic [QUO_W-1:0] num;
  logic [QUO_W-1:0] quo;
  logic          div_done;

  assign idx_last = idx_q == AW'(FRAMES - 1);
  assign rd_free  = ram_rdata[ID_W];
  assign rd_owner = ram_rdata[ID_W-1:0];
  assign num      = QUO_W'(mem_q) + QUO_W'(page_q) - QUO_W'(1);

  // entry read last cycle is acted on now
  always_comb begin
    if (func_q == FN_FREE) begin
      hit = rd_pend_q && !rd_free && (rd_owner == owner_q);
    end else begin
      hit = rd_pend_q && rd_free && (left_q != '0);
    end
    ram_we    = cmd_i.clr_wr || hit;
    ram_waddr = cmd_i.clr_wr ? idx_q : wr_idx_q;
    ram_wdata = cmd_i.clr_wr ? {1'b1, ID_W'(0)} : {func_q == FN_FREE, owner_q};
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_wr || cmd_i.scan_rd) begin
      idx_d = idx_last ? '0 : idx_q + 1'b1;
    end
    chg_d = chg_q;
    if (cmd_i.take) begin
      chg_d = '0;
    end else if (hit) begin
      chg_d = chg_q + 1'b1;
    end
    left_d = left_q;
    if (cmd_i.left_load) begin
      left_d = CW'(quo);
    end else if (hit && func_q == FN_ALLOC) begin
      left_d = left_q - 1'b1;
    end
    // errors leave chg at zero, so one update serves every outcome
    free_cnt_d = free_cnt_q;
    if (cmd_i.res_load) begin
      free_cnt_d = (func_q == FN_FREE) ? free_cnt_q + chg_q : free_cnt_q - chg_q;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    chg_w  = 32'(chg_q);
    free_w = 32'(free_cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      free_cnt_q  <= CW'(FRAMES);
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      rd_pend_q   <= cmd_i.scan_rd;
      free_cnt_q  <= free_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= idx_q;
    chg_q    <= chg_d;
    left_q   <= left_d;
    if (cmd_i.take) begin
      func_q  <= pfa_func_e'(func_i);
      owner_q <= owner_id_i;
      mem_q   <= mem_bytes_i;
      page_q  <= page_bytes_i;
    end
    if (cmd_i.res_load) begin
      status_q   <= cmd_i.res_code;
      changed_q  <= chg_w[OUT_CNT_W-1:0];
      free_out_q <= free_w[OUT_CNT_W-1:0];
    end
  end

  pfa_ram #(
    .WIDTH (WW),
    .DEPTH (FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  pfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (page_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    sts_o.idx_last  = idx_last;
    sts_o.is_free   = func_q == FN_FREE;
    sts_o.page_zero = page_q == '0;
    sts_o.div_done  = div_done;
    sts_o.need_ok   = (quo != '0) && (32'(quo) <= 32'(free_cnt_q));
    sts_o.res_room  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign frames_changed_o = changed_q;
  assign free_frames_o    = free_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfa_ctrl.sv =====
// Controller state machine: clearing pass, request sequencing, result hand-off.
// Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o
);
  import pfa_pkg::*;

  pfa_state_e  state_q, state_d;
  pfa_status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    cmd_o          = '0;
    cmd_o.res_code = code_q;
    in_stall_o     = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.is_free) begin
          code_d  = ST_DONE;
          state_d = S_SCAN;
        end else if (sts_i.page_zero) begin
          code_d  = ST_BAD_PAGE;
          state_d = S_RESULT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.need_ok) begin
          cmd_o.left_load = 1'b1;
          code_d          = ST_DONE;
          state_d         = S_SCAN;
        end else begin
          code_d  = ST_NO_ROOM;
          state_d = S_RESULT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_RESULT;  // last entry written back here
      end
      S_RESULT: begin
        if (sts_i.res_room) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/paged_frame_allocator.sv =====
// Top level of the paged frame allocator: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dp (which holds pfa_ram and pfa_div).
`default_nettype none

// Channel  Handshake                Payload
// -------  -----------------------  ----------------------------------------------
// in       in_valid_i/in_stall_o    func_i, owner_id_i, mem_bytes_i, page_bytes_i
// out      out_valid_o/out_stall_i  status_o, frames_changed_o, free_frames_o
//
// One request at a time. A free goes straight to the scan; an allocate first divides
// for the frame count, then scans; a zero page size, or an allocate refused for room
// or zero size, goes to the result without a scan. The scan over the owner table RAM
// takes one frame per cycle through its single read port.
// After reset a clearing pass marks every frame free; no
// request is taken until it ends.
// A result waits in the output register under out_stall_i while the next
// request is taken; the block only holds off if a second result is ready.

module paged_frame_allocator #(
  parameter int unsigned FRAMES = pfa_pkg::FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [pfa_pkg::ID_W-1:0]      owner_id_i,
  input  logic [pfa_pkg::BYTES_W-1:0]   mem_bytes_i,
  input  logic [pfa_pkg::BYTES_W-1:0]   page_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pfa_pkg::STATUS_W-1:0]  status_o,
  output logic [pfa_pkg::OUT_CNT_W-1:0] frames_changed_o,
  output logic [pfa_pkg::OUT_CNT_W-1:0] free_frames_o
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;  // controller -> datapath
  pfa_sts_t sts;  // datapath -> controller

  // sequencing: clear pass, decide, divide, check, scan, result
  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // owner table entries are {free, owner}; scan is read, then write-back
  // of the same entry in the following cycle
  pfa_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .owner_id_i       (owner_id_i),
    .mem_bytes_i      (mem_bytes_i),
    .page_bytes_i     (page_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .frames_changed_o (frames_changed_o),
    .free_frames_o    (free_frames_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pfa_checker.sv =====
// Port-level checks for the paged frame allocator, bound to the top level.
// Depends on pfa_pkg and paged_frame_allocator.
`default_nettype none

module pfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pfa_pkg::STATUS_W-1:0]  status_o,
  input logic [pfa_pkg::OUT_CNT_W-1:0] frames_changed_o,
  input logic [pfa_pkg::OUT_CNT_W-1:0] free_frames_o
);
  import pfa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(frames_changed_o) && $stable(free_frames_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DONE || status_o == ST_BAD_PAGE
      || status_o == ST_NO_ROOM)
    else $error("unknown status code");

  // a rejected allocate touches no frame
  a_reject_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> frames_changed_o == '0)
    else $error("rejected request reports changed frames");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .frames_changed_o (frames_changed_o),
  .free_frames_o    (free_frames_o)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for paged_frame_allocator: a table of directed requests, then
// random requests under four idle/stall mixes, each report checked against a local model.
// Depends on pfa_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;
  import pfa_pkg::*;

  localparam int unsigned FRAMES = FRAMES_DEF;
  // A free or a granted allocate scans the whole table once; allow for that and some slack.
  localparam int unsigned TAIL_CYCLES = FRAMES + 40;
  // The clearing pass after reset plus one full scan is the longest spell with no request
  // or report moving; stalls on either side add a little. Taken several times over.
  localparam int unsigned WATCHDOG_LIMIT = 10 * (FRAMES + 40);
  localparam int unsigned RANDOM_PER_PHASE = 410;
  localparam int unsigned POOL = 8;

  // One report as the block gives it.
  typedef struct packed {
    pfa_status_e          status;
    logic [OUT_CNT_W-1:0] changed;
    logic [OUT_CNT_W-1:0] free_left;
  } frame_report_t;

  // One row of the directed table. Where typed is set the report is written out by hand.
  typedef struct {
    pfa_func_e          f;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] mem;
    logic [BYTES_W-1:0] page;
    bit                 typed;
    frame_report_t      rep;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 func_i = 1'b0;
  logic [ID_W-1:0]      owner_id_i = '0;
  logic [BYTES_W-1:0]   mem_bytes_i = '0;
  logic [BYTES_W-1:0]   page_bytes_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [OUT_CNT_W-1:0] frames_changed_o;
  logic [OUT_CNT_W-1:0] free_frames_o;

  // Local copy of the owner table.
  bit              slot_free [FRAMES];
  logic [ID_W-1:0] slot_owner[FRAMES];
  int unsigned     free_total;

  frame_report_t   pending_reports[$];
  dir_row_t        dir_rows[$];
  logic [ID_W-1:0] owner_pool[POOL];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned reports_checked = 0;
  int unsigned stuck = 0;
  int unsigned status_count[3] = '{0, 0, 0};

  paged_frame_allocator #(
    .FRAMES(FRAMES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .owner_id_i      (owner_id_i),
    .mem_bytes_i     (mem_bytes_i),
    .page_bytes_i    (page_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .frames_changed_o(frames_changed_o),
    .free_frames_o   (free_frames_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the local table and work out the report it should give.
  // Allocation takes the lowest free frames first; a refusal leaves the table alone.
  function automatic frame_report_t book_frames(input pfa_func_e f,
                                                input logic [ID_W-1:0] id,
                                                input logic [BYTES_W-1:0] mem,
                                                input logic [BYTES_W-1:0] page);
    frame_report_t rep;
    int unsigned   need;
    int unsigned   moved;
    moved = 0;
    rep.status = ST_DONE;
    if (f == FN_FREE) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (!slot_free[i] && slot_owner[i] == id) begin
          slot_free[i] = 1'b1;
          moved++;
        end
      end
      free_total += moved;
    end else if (page == '0) begin
      rep.status = ST_BAD_PAGE;
    end else begin
      // ceil(mem / page); zero size rounds to zero frames and is refused
      need = (32'(mem) + 32'(page) - 32'd1) / 32'(page);
      if (need == 0 || need > free_total) begin
        rep.status = ST_NO_ROOM;
      end else begin
        for (int i = 0; i < FRAMES && moved < need; i++) begin
          if (slot_free[i]) begin
            slot_free[i]  = 1'b0;
            slot_owner[i] = id;
            moved++;
          end
        end
        free_total -= need;
      end
    end
    rep.changed   = OUT_CNT_W'(moved);
    rep.free_left = OUT_CNT_W'(free_total);
    status_count[rep.status]++;
    return rep;
  endfunction

  task automatic add_row(input pfa_func_e f, input logic [ID_W-1:0] id,
                         input logic [BYTES_W-1:0] mem, input logic [BYTES_W-1:0] page,
                         input bit typed, input pfa_status_e st, input int chg,
                         input int left);
    dir_row_t row;
    row.f             = f;
    row.id            = id;
    row.mem           = mem;
    row.page          = page;
    row.typed         = typed;
    row.rep.status    = st;
    row.rep.changed   = OUT_CNT_W'(chg);
    row.rep.free_left = OUT_CNT_W'(left);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Present one request, hold it until taken, then book it. Valid stays high between
  // back-to-back requests; the sender idles cycle by cycle at idle_pct.
  task automatic send_request(input pfa_func_e f, input logic [ID_W-1:0] id,
                              input logic [BYTES_W-1:0] mem,
                              input logic [BYTES_W-1:0] page,
                              input bit typed, input frame_report_t typed_rep);
    frame_report_t rep;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    owner_id_i   <= id;
    mem_bytes_i  <= mem;
    page_bytes_i <= page;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    rep = book_frames(f, id, mem, page);
    pending_reports.insert(pending_reports.size(), typed ? typed_rep : rep);
    sent++;
  endtask

  // Sender stops until every outstanding report is back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  // Mostly well-formed allocates and frees on a small pool of owners, so the table fills,
  // refuses and empties again; the rest is noise, zero page and zero size.
  task automatic draw_request(output pfa_func_e f, output logic [ID_W-1:0] id,
                              output logic [BYTES_W-1:0] mem,
                              output logic [BYTES_W-1:0] page);
    int unsigned pick;
    int unsigned k;
    int unsigned span;
    pick = $urandom_range(0, 99);
    f    = FN_ALLOC;
    id   = owner_pool[$urandom_range(0, POOL - 1)];
    mem  = '0;
    page = '0;
    if (pick < 10) begin
      // noise; random ids only on frees so no frames leak to owners never freed again
      f    = pfa_func_e'($urandom_range(0, 1));
      mem  = BYTES_W'($urandom);
      page = BYTES_W'($urandom);
      if (f == FN_FREE) id = ID_W'($urandom);
    end else if (pick < 14) begin
      mem = BYTES_W'($urandom);
    end else if (pick < 17) begin
      page = BYTES_W'($urandom_range(1, 65535));
    end else if (pick < 45) begin
      f = FN_FREE;
    end else begin
      page = (pick < 55) ? BYTES_W'(1) : BYTES_W'($urandom_range(1, 4096));
      k    = $urandom_range(1, 24);
      span = 32'(page) * k;
      if (span > 65535) span = 65535;
      mem = BYTES_W'(span - $urandom_range(0, 32'(page) - 1));
    end
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Report checker: oldest expectation first.
  always @(posedge clk_i) begin : check_reports
    frame_report_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("report with no request outstanding: status %0d changed %0d free %0d",
               status_o, frames_changed_o, free_frames_o);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (frames_changed_o !== want.changed) begin
          $error("frames_changed: expected %0d, got %0d", want.changed, frames_changed_o);
          errors++;
        end
        if (free_frames_o !== want.free_left) begin
          $error("free_frames: expected %0d, got %0d", want.free_left, free_frames_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a report moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    pfa_func_e          f;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] mem;
    logic [BYTES_W-1:0] page;
    frame_report_t      blank;
    blank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      slot_free[i]  = 1'b1;
      slot_owner[i] = '0;
    end
    free_total = FRAMES;
    for (int i = 0; i < POOL; i++) owner_pool[i] = ID_W'($urandom);

    // Directed table. Rows up to the full-table free carry hand-worked reports.
    add_row(FN_FREE,  16'h0000, 16'h0000, 16'h0000, 1'b1, ST_DONE,     0,   256);
    add_row(FN_ALLOC, 16'h0001, 16'h0040, 16'h0000, 1'b1, ST_BAD_PAGE, 0,   256);
    add_row(FN_ALLOC, 16'h0001, 16'h0000, 16'h0001, 1'b1, ST_NO_ROOM,  0,   256);
    add_row(FN_ALLOC, 16'h0001, 16'hFFFF, 16'h0001, 1'b1, ST_NO_ROOM,  0,   256);
    add_row(FN_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_DONE,     1,   255);
    add_row(FN_ALLOC, 16'h0001, 16'h0100, 16'h0001, 1'b1, ST_NO_ROOM,  0,   255);
    add_row(FN_ALLOC, 16'h0001, 16'h00FF, 16'h0001, 1'b1, ST_DONE,     255, 0);
    add_row(FN_ALLOC, 16'h0002, 16'h0001, 16'h0001, 1'b1, ST_NO_ROOM,  0,   0);
    add_row(FN_FREE,  16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_DONE,     1,   1);
    add_row(FN_FREE,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_DONE,     0,   1);
    add_row(FN_FREE,  16'h0001, 16'h0000, 16'h0000, 1'b1, ST_DONE,     255, 256);
    add_row(FN_ALLOC, 16'h0003, 16'h0100, 16'h0001, 1'b1, ST_DONE,     256, 0);
    add_row(FN_FREE,  16'h0003, 16'h0000, 16'h0000, 1'b1, ST_DONE,     256, 256);
    // holes and accumulation: owner 5 allocates twice, owner 6 leaves a hole for owner 7
    add_row(FN_ALLOC, 16'h0005, 16'd10,   16'd3,    1'b0, ST_DONE,     0,   0);
    add_row(FN_ALLOC, 16'h0006, 16'd7,    16'd7,    1'b0, ST_DONE,     0,   0);
    add_row(FN_ALLOC, 16'h0005, 16'hFFFF, 16'hFFFF, 1'b0, ST_DONE,     0,   0);
    add_row(FN_FREE,  16'h0006, 16'h0000, 16'h0000, 1'b0, ST_DONE,     0,   0);
    add_row(FN_ALLOC, 16'h0007, 16'd3,    16'd1,    1'b0, ST_DONE,     0,   0);
    add_row(FN_FREE,  16'h0005, 16'h0000, 16'h0000, 1'b0, ST_DONE,     0,   0);
    add_row(FN_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1'b0, ST_DONE,     0,   0);
    add_row(FN_FREE,  16'h0007, 16'h0000, 16'h0000, 1'b0, ST_DONE,     0,   0);
    add_row(FN_ALLOC, 16'hABCD, 16'hFFFF, 16'h0100, 1'b0, ST_DONE,     0,   0);
    add_row(FN_FREE,  16'hABCD, 16'h0000, 16'h0000, 1'b0, ST_DONE,     0,   0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].f, dir_rows[r].id, dir_rows[r].mem, dir_rows[r].page,
                   dir_rows[r].typed, dir_rows[r].rep);
    end

    // Random phases: none, sender idle, receiver stall, both. Each starts from a
    // drained block so that a fresh request meets an empty pipe at least once.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 50;
        end
        default: begin
          idle_pct = 28;
          stall_pct <= 28;
        end
      endcase
      hold_until_drained();
      repeat (RANDOM_PER_PHASE) begin
        draw_request(f, id, mem, page);
        send_request(f, id, mem, page, 1'b0, blank);
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests (%0d directed), four idle/stall mixes, %0d reports checked.",
             sent, dir_rows.size(), reports_checked);
    $display("Outcomes: %0d done, %0d bad page size, %0d refused for room or zero size.",
             status_count[ST_DONE], status_count[ST_BAD_PAGE], status_count[ST_NO_ROOM]);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/pfa_div.sv
rtl/core/pfa_dp.sv
rtl/core/pfa_ctrl.sv
rtl/core/paged_frame_allocator.sv
rtl/core/pfa_checker.sv
test/tb.sv
